/* rtl/dns_name_label_encoder_defines.svh */
// assertion macros shared by the dns name label encoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define DNSLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define DNSLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dnsle_pkg.sv */
// constants and state codes for the dns name label encoder
// no dependencies; used by the top level and the label memory
package dnsle_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2e;

    // sequencer state codes
    localparam int unsigned STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_LEN  = 2'd1;
    localparam logic [STATE_W-1:0] ST_DAT  = 2'd2;

    // m_tuser bit positions
    localparam int unsigned USER_W       = 2;
    localparam int unsigned USER_END_BIT = 0;
    localparam int unsigned USER_OVF_BIT = 1;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* rtl/dnsle_label_ram.sv */
// label character buffer: one write port, one read port, registered read data
// depends on dnsle_pkg for the byte type
module dnsle_label_ram #(
    parameter int unsigned DEPTH  = 63,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  dnsle_pkg::byte_t  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output dnsle_pkg::byte_t  rd_data
);

    dnsle_pkg::byte_t mem [DEPTH];
    dnsle_pkg::byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dns_name_label_encoder.sv */
// dns name label encoder: an ordinary character is stored and gives no word; a dot or
// the last character ends the label, and input waits until it is out. the length word
// goes from ST_LEN into the output register, then one label byte per cycle while
// m_tready holds, from the single read port of the label memory. reset clears
// sequencer, count and overflow flag; the memory is not cleared, only entries of the
// current label are read. depends on dnsle_pkg, dnsle_label_ram, the defines header
`include "dns_name_label_encoder_defines.svh"

module dns_name_label_encoder #(
    parameter int unsigned MAX_LABEL = 63
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dnsle_pkg::BYTE_W-1:0] s_tdata,   // [7:0] char_in
    input  logic                         s_tlast,   // name_last
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dnsle_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                         m_tlast,   // run_last
    output logic [dnsle_pkg::USER_W-1:0] m_tuser    // [0] name_end, [1] label_overflow
);

    localparam int unsigned CNT_W  = $clog2(MAX_LABEL + 1);
    localparam int unsigned ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LABEL);

    logic [dnsle_pkg::STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_seen_reg, ovf_seen_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ovf_reg, ovf_next;
    logic             end_reg, end_next;

    logic             m_tvalid_reg;
    dnsle_pkg::byte_t out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_end_reg, out_end_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_load;
    logic             out_free;

    logic             in_acc;
    logic             is_dot;
    logic             can_store;
    logic             wr_en;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    dnsle_pkg::byte_t rd_data;
    logic [CNT_W-1:0] idx_inc;

    assign in_acc    = s_tvalid && s_tready;
    assign is_dot    = (s_tdata == dnsle_pkg::DOT_CHAR);
    assign can_store = (count_reg < MAX_CNT);
    assign wr_en     = in_acc && !is_dot && can_store;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign s_tready  = (state_reg == dnsle_pkg::ST_IDLE);

    dnsle_label_ram #(
        .DEPTH  (MAX_LABEL),
        .ADDR_W (ADDR_W)
    ) u_label_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_seen_next = ovf_seen_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        ovf_next      = ovf_reg;
        end_next      = end_reg;
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_end_next  = out_end_reg;
        out_ovf_next  = out_ovf_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[ADDR_W-1:0];

        case (state_reg)
            dnsle_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (!is_dot) begin
                        if (can_store) begin
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            ovf_seen_next = 1'b1;
                        end
                    end
                    if (is_dot || s_tlast) begin
                        // hand the finished label to the emitter, start a fresh one
                        len_next      = count_next;
                        ovf_next      = ovf_seen_next;
                        end_next      = s_tlast;
                        idx_next      = '0;
                        count_next    = '0;
                        ovf_seen_next = 1'b0;
                        state_next    = dnsle_pkg::ST_LEN;
                    end
                end
            end
            dnsle_pkg::ST_LEN: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = dnsle_pkg::byte_t'(len_reg);
                    out_last_next = (len_reg == '0);
                    out_end_next  = end_reg && (len_reg == '0);
                    out_ovf_next  = ovf_reg;
                    if (len_reg == '0) begin
                        state_next = dnsle_pkg::ST_IDLE;
                    end else begin
                        // fetch the first character while the length word goes out
                        rd_en      = 1'b1;
                        state_next = dnsle_pkg::ST_DAT;
                    end
                end
            end
            dnsle_pkg::ST_DAT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = rd_data;
                    out_last_next = (idx_inc == len_reg);
                    out_end_next  = end_reg && (idx_inc == len_reg);
                    out_ovf_next  = ovf_reg;
                    idx_next      = idx_inc;
                    if (idx_inc == len_reg) begin
                        state_next = dnsle_pkg::ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                state_next = dnsle_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dnsle_pkg::ST_IDLE;
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        ovf_reg      <= ovf_next;
        end_reg      <= end_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid                          = m_tvalid_reg;
    assign m_tdata                           = out_byte_reg;
    assign m_tlast                           = out_last_reg;
    assign m_tuser[dnsle_pkg::USER_END_BIT]  = out_end_reg;
    assign m_tuser[dnsle_pkg::USER_OVF_BIT]  = out_ovf_reg;

    `DNSLE_ASSERT_SAME(a_end_is_last, m_tvalid && out_end_reg, m_tlast, "end word not last")
    `DNSLE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= MAX_CNT, "label count past max")
    `DNSLE_ASSERT_SAME(a_idx_bound, state_reg == dnsle_pkg::ST_DAT, idx_reg < len_reg, "bad index")
    `DNSLE_ASSERT_NEXT(a_flush_start, in_acc && (is_dot || s_tlast), !s_tready, "no flush")

endmodule
